[design/cacb_pkg.sv]
package cacb_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    REG_BASE_SPEED       = 3'd0,
    REG_STOP_DIST_MM     = 3'd1,
    REG_WALL_GAIN        = 3'd2,
    REG_CENTER_HALF_MM   = 3'd3,
    REG_SIDE_WALL_MM     = 3'd4,
    REG_ANCHOR_MM        = 3'd5,
    REG_TICKS_PER_CM     = 3'd6,
    REG_CORRECTION_LIMIT = 3'd7
  } cacb_reg_t;

  localparam int unsigned CFG_DATA_W = 15;

  // Reset values of the configuration registers
  localparam logic [14:0] BASE_SPEED_RST       = 15'd3840;
  localparam logic [9:0]  STOP_DIST_MM_RST     = 10'd40;
  localparam logic [7:0]  WALL_GAIN_RST        = 8'd51;
  localparam logic [7:0]  CENTER_HALF_MM_RST   = 8'd65;
  localparam logic [12:0] SIDE_WALL_MM_RST     = 13'd150;
  localparam logic [12:0] ANCHOR_MM_RST        = 13'd100;
  localparam logic [7:0]  TICKS_PER_CM_RST     = 8'd23;
  localparam logic [13:0] CORRECTION_LIMIT_RST = 14'd2048;

  // Front readings at or above this are out of range
  localparam logic [13:0] FRONT_VALID_MAX = 14'd8000;

  // Live configuration, shared with the steering path
  typedef struct packed {
    logic [14:0] base_speed;
    logic [9:0]  stop_dist_mm;
    logic [7:0]  wall_gain;
    logic [7:0]  center_half_mm;
    logic [12:0] side_wall_mm;
    logic [12:0] anchor_mm;
    logic [7:0]  ticks_per_cm;
    logic [13:0] correction_limit;
  } cacb_cfg_t;

endpackage

[design/cacb_steer.sv]
module cacb_steer (
  input  cacb_pkg::cacb_cfg_t cfg,
  input  logic                sensor_valid,
  input  logic signed [13:0]  left_mm,
  input  logic signed [13:0]  right_mm,
  output logic signed [15:0]  left_target,
  output logic signed [15:0]  right_target
);
  import cacb_pkg::*;

  logic signed [14:0] l_ext;
  logic signed [14:0] r_ext;
  logic signed [14:0] side_ext;
  logic signed [15:0] l2;
  logic signed [15:0] r2;
  logic signed [15:0] ch;
  logic               near_l;
  logic               near_r;
  logic               wall;
  logic signed [15:0] err;
  logic signed [24:0] corr_full;
  logic signed [24:0] lim;
  logic signed [24:0] neg_lim;
  logic signed [24:0] corr_sat;
  logic signed [14:0] corr;
  logic signed [17:0] lt_wide;
  logic signed [17:0] rt_wide;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Wall detection and steering error in mm
  always_comb begin
    l_ext    = {left_mm[13], left_mm};
    r_ext    = {right_mm[13], right_mm};
    side_ext = {2'b00, cfg.side_wall_mm};
    // doubled readings keep their sign, so a -1 reading stays negative
    l2       = {left_mm[13], left_mm, 1'b0};
    r2       = {right_mm[13], right_mm, 1'b0};
    ch       = {8'd0, cfg.center_half_mm};
    near_l   = l_ext < side_ext;
    near_r   = r_ext < side_ext;
    wall     = 1'b0;
    err      = '0;
    if (sensor_valid) begin
      if (near_l && near_r) begin
        err  = {l_ext[14], l_ext} - {r_ext[14], r_ext};
        wall = 1'b1;
      end else if (near_l) begin
        if (l2 < ch) begin
          err  = l2 - ch;
          wall = 1'b1;
        end
      end else if (near_r) begin
        if (r2 < ch) begin
          err  = ch - r2;
          wall = 1'b1;
        end
      end
    end
  end

  // Gain, saturation to the correction limit, wheel targets
  always_comb begin
    corr_full = err * $signed({1'b0, cfg.wall_gain});
    lim       = {11'd0, cfg.correction_limit};
    neg_lim   = -lim;
    if (!wall) begin
      corr_sat = '0;
    end else if (corr_full > lim) begin
      corr_sat = lim;
    end else if (corr_full < neg_lim) begin
      corr_sat = neg_lim;
    end else begin
      corr_sat = corr_full;
    end
    corr    = corr_sat[14:0];
    lt_wide = {3'b000, cfg.base_speed} - {{3{corr[14]}}, corr};
    rt_wide = {3'b000, cfg.base_speed} + {{3{corr[14]}}, corr};
    left_target  = sat16(lt_wide);
    right_target = sat16(rt_wide);
  end

endmodule

[design/corridor_centering_anchor_brake.sv]
// Corridor-centering wall follower with anchor-point braking. One control
// tick is one input word; each accepted word yields exactly one result word,
// in order. The block takes a word every cycle while in_stall is low: the
// word is captured in an input register, steering, anchor and odometry
// logic runs in one pass, and the result sits in an output register. Run
// state (blind mode, start count, tick target, done) is updated as a word
// leaves the input register, so the next word already sees it. in_stall
// rises only when both registers are full and out_stall is high. The
// configuration port is always ready; write it only while no words are in
// flight. There is no clearing pass after reset.
module corridor_centering_anchor_brake (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [cacb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             begin_run,
  input  logic signed [31:0]               encoder_count,
  input  logic                             sensor_valid,
  input  logic signed [13:0]               front_mm,
  input  logic signed [13:0]               left_mm,
  input  logic signed [13:0]               right_mm,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               left_target,
  output logic signed [15:0]               right_target,
  output logic                             blind_active,
  output logic                             done_res
);
  import cacb_pkg::*;

  cacb_cfg_t cfg;

  // Input register
  logic               s1_valid;
  logic               s1_begin;
  logic [31:0]        s1_enc;
  logic               s1_sensor;
  logic signed [13:0] s1_front;
  logic signed [13:0] s1_left;
  logic signed [13:0] s1_right;

  // Run state
  logic        blind_mode;
  logic        finished;
  logic [31:0] blind_start;
  logic [20:0] blind_prod;   // rem * ticks_per_cm; tick target is this / 10

  logic        blind_mode_next;
  logic        finished_next;
  logic [31:0] blind_start_next;
  logic [20:0] blind_prod_next;

  logic               advance;
  logic               bm_eff;
  logic               fin_eff;
  logic               anchor;
  logic signed [14:0] rem;
  logic [20:0]        prod;
  logic [31:0]        diff;
  logic [31:0]        mag;
  logic [21:0]        mag10;
  logic               reached;
  logic               end_run;
  logic signed [15:0] steer_left;
  logic signed [15:0] steer_right;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_speed       <= BASE_SPEED_RST;
      cfg.stop_dist_mm     <= STOP_DIST_MM_RST;
      cfg.wall_gain        <= WALL_GAIN_RST;
      cfg.center_half_mm   <= CENTER_HALF_MM_RST;
      cfg.side_wall_mm     <= SIDE_WALL_MM_RST;
      cfg.anchor_mm        <= ANCHOR_MM_RST;
      cfg.ticks_per_cm     <= TICKS_PER_CM_RST;
      cfg.correction_limit <= CORRECTION_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cacb_reg_t'(cfg_index))
        REG_BASE_SPEED:       cfg.base_speed       <= cfg_data[14:0];
        REG_STOP_DIST_MM:     cfg.stop_dist_mm     <= cfg_data[9:0];
        REG_WALL_GAIN:        cfg.wall_gain        <= cfg_data[7:0];
        REG_CENTER_HALF_MM:   cfg.center_half_mm   <= cfg_data[7:0];
        REG_SIDE_WALL_MM:     cfg.side_wall_mm     <= cfg_data[12:0];
        REG_ANCHOR_MM:        cfg.anchor_mm        <= cfg_data[12:0];
        REG_TICKS_PER_CM:     cfg.ticks_per_cm     <= cfg_data[7:0];
        REG_CORRECTION_LIMIT: cfg.correction_limit <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Input register: loads whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_begin  <= begin_run;
      s1_enc    <= encoder_count;
      s1_sensor <= sensor_valid;
      s1_front  <= front_mm;
      s1_left   <= left_mm;
      s1_right  <= right_mm;
    end
  end

  cacb_steer u_steer (
    .cfg          (cfg),
    .sensor_valid (s1_sensor),
    .left_mm      (s1_left),
    .right_mm     (s1_right),
    .left_target  (steer_left),
    .right_target (steer_right)
  );

  // Anchor detection and blind odometry
  always_comb begin
    bm_eff  = blind_mode && !s1_begin;
    fin_eff = finished && !s1_begin;
    anchor  = s1_sensor && !bm_eff && (s1_front > 14'sd0) &&
              (s1_front < $signed(FRONT_VALID_MAX)) &&
              ({1'b0, s1_front} <= $signed({2'b00, cfg.anchor_mm}));
    rem     = {s1_front[13], s1_front} - $signed({5'd0, cfg.stop_dist_mm});
    prod    = rem[12:0] * cfg.ticks_per_cm;
    // floor(p / 10) <= mag  <=>  10 * mag + 9 >= p; targets stay below 2^18
    diff    = s1_enc - blind_start;
    mag     = diff[31] ? (32'd0 - diff) : diff;
    mag10   = {1'b0, mag[17:0], 3'b000} + {3'b000, mag[17:0], 1'b0} + 22'd9;
    reached = (|mag[31:18]) || (mag10 >= {1'b0, blind_prod});

    blind_mode_next  = bm_eff;
    finished_next    = fin_eff;
    blind_start_next = blind_start;
    blind_prod_next  = blind_prod;
    end_run          = 1'b0;
    if (fin_eff) begin
      end_run = 1'b1;
    end else if (anchor && (rem <= 15'sd0)) begin
      end_run = 1'b1;
    end else if (anchor) begin
      blind_start_next = s1_enc;
      blind_prod_next  = prod;
      blind_mode_next  = 1'b1;
      // on the anchor tick the distance run is zero
      end_run          = prod < 21'd10;
    end else if (bm_eff) begin
      end_run = reached;
    end
    if (end_run) begin
      finished_next   = 1'b1;
      blind_mode_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blind_mode  <= 1'b0;
      finished    <= 1'b0;
      blind_start <= '0;
      blind_prod  <= '0;
    end else if (s1_valid && advance) begin
      blind_mode  <= blind_mode_next;
      finished    <= finished_next;
      blind_start <= blind_start_next;
      blind_prod  <= blind_prod_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (end_run) begin
        left_target  <= '0;
        right_target <= '0;
        blind_active <= 1'b0;
        done_res     <= 1'b1;
      end else begin
        left_target  <= steer_left;
        right_target <= steer_right;
        blind_active <= blind_mode_next;
        done_res     <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> left_target == 16'sd0 && right_target == 16'sd0 &&
      !blind_active)
    else $error("done word carries nonzero speed or blind flag");

  a_state_excl: assert property (@(posedge clk) disable iff (rst)
    !(finished && blind_mode))
    else $error("finished and blind mode both set");

  a_stay_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && !s1_begin && finished |=> out_valid && done_res)
    else $error("finished run produced a word without done");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with an empty stage");
`endif

endmodule

[verif/wheel_target_checker.sv]
`timescale 1ns / 1ps

// Watches the config, tick and result channels of the corridor controller,
// predicts each result word from its own copy of the registers and run state,
// and compares it with the oldest outstanding prediction.
module wheel_target_checker
  import cacb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               begin_run,
  input  logic signed [31:0] encoder_count,
  input  logic               sensor_valid,
  input  logic signed [13:0] front_mm,
  input  logic signed [13:0] left_mm,
  input  logic signed [13:0] right_mm,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] left_target,
  input  logic signed [15:0] right_target,
  input  logic               blind_active,
  input  logic               done_res,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 stops
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               blind;
    logic               done;
  } wheel_cmd_t;

  // Shadow registers and run state
  cacb_cfg_t   cfg;
  logic        braking = 1'b0;
  logic        run_over = 1'b0;
  logic [31:0] brake_origin = '0;
  logic [19:0] brake_ticks = '0;

  wheel_cmd_t expected_cmds[$];
  int err_cnt = 0;
  int result_cnt = 0;
  int stop_cnt = 0;

  // One control tick: steering, anchor detection and blind braking
  function automatic wheel_cmd_t predict_targets(input logic go, input logic [31:0] enc,
                                                 input logic sv,
                                                 input logic signed [13:0] fr,
                                                 input logic signed [13:0] lf,
                                                 input logic signed [13:0] rg);
    wheel_cmd_t cmd;
    longint lw, rw, err, corr, lim, side, half, gain, f, l, r, rem;
    logic [31:0] delta, mag;
    logic steer, ending;
    lw = cfg.base_speed;
    rw = cfg.base_speed;
    side = cfg.side_wall_mm;
    half = cfg.center_half_mm;
    gain = cfg.wall_gain;
    lim = cfg.correction_limit;
    f = fr;
    l = lf;
    r = rg;
    err = 0;
    steer = 1'b0;
    ending = 1'b0;

    if (go) begin
      braking = 1'b0;
      run_over = 1'b0;
    end

    if (run_over) begin
      ending = 1'b1;
    end else begin
      if (sv) begin
        // wall centering or one-sided repulsion
        if (l < side && r < side) begin
          err = l - r;
          steer = 1'b1;
        end else if (l < side) begin
          if (2 * l < half) begin
            err = 2 * l - half;
            steer = 1'b1;
          end
        end else if (r < side) begin
          if (2 * r < half) begin
            err = half - 2 * r;
            steer = 1'b1;
          end
        end
        if (steer) begin
          corr = err * gain;
          if (corr > lim) corr = lim;
          if (corr < -lim) corr = -lim;
          lw = lw - corr;
          rw = rw + corr;
        end

        // anchor point
        if (!braking && f > 0 && f < longint'(FRONT_VALID_MAX) &&
            f <= longint'(cfg.anchor_mm)) begin
          rem = f - longint'(cfg.stop_dist_mm);
          if (rem <= 0) begin
            ending = 1'b1;
          end else begin
            brake_ticks = (rem * longint'(cfg.ticks_per_cm)) / 10;
            brake_origin = enc;
            braking = 1'b1;
          end
        end
      end

      // blind odometry, distance taken mod 2^32
      if (braking && !ending) begin
        delta = enc - brake_origin;
        mag = delta[31] ? (32'd0 - delta) : delta;
        if (mag >= {12'd0, brake_ticks}) ending = 1'b1;
      end
    end

    if (ending) begin
      run_over = 1'b1;
      braking = 1'b0;
      cmd = '{16'sd0, 16'sd0, 1'b0, 1'b1};
      return cmd;
    end

    if (lw > 32767) lw = 32767;
    else if (lw < -32768) lw = -32768;
    if (rw > 32767) rw = 32767;
    else if (rw < -32768) rw = -32768;
    cmd.left = lw[15:0];
    cmd.right = rw[15:0];
    cmd.blind = braking;
    cmd.done = 1'b0;
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    wheel_cmd_t got, want;
    if (rst) begin
      cfg = '{BASE_SPEED_RST, STOP_DIST_MM_RST, WALL_GAIN_RST, CENTER_HALF_MM_RST,
              SIDE_WALL_MM_RST, ANCHOR_MM_RST, TICKS_PER_CM_RST, CORRECTION_LIMIT_RST};
      braking = 1'b0;
      run_over = 1'b0;
      brake_origin = '0;
      brake_ticks = '0;
      expected_cmds.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cacb_reg_t'(cfg_index))
          REG_BASE_SPEED:       cfg.base_speed = cfg_data[14:0];
          REG_STOP_DIST_MM:     cfg.stop_dist_mm = cfg_data[9:0];
          REG_WALL_GAIN:        cfg.wall_gain = cfg_data[7:0];
          REG_CENTER_HALF_MM:   cfg.center_half_mm = cfg_data[7:0];
          REG_SIDE_WALL_MM:     cfg.side_wall_mm = cfg_data[12:0];
          REG_ANCHOR_MM:        cfg.anchor_mm = cfg_data[12:0];
          REG_TICKS_PER_CM:     cfg.ticks_per_cm = cfg_data[7:0];
          REG_CORRECTION_LIMIT: cfg.correction_limit = cfg_data[13:0];
          default: ;
        endcase
      end

      // result words against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{left_target, right_target, blind_active, done_res};
        if (expected_cmds.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: result word with none outstanding: L=%0d R=%0d blind=%0b done=%0b",
                     $time, got.left, got.right, got.blind, got.done);
        end else begin
          want = expected_cmds.pop_front();
          result_cnt++;
          if (got.left !== want.left || got.right !== want.right ||
              got.blind !== want.blind || got.done !== want.done) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch, expected L=%0d R=%0d blind=%0b done=%0b, got L=%0d R=%0d blind=%0b done=%0b",
                       $time, want.left, want.right, want.blind, want.done,
                       got.left, got.right, got.blind, got.done);
          end
        end
      end

      // accepted ticks
      if (in_valid && !in_stall) begin
        want = predict_targets(begin_run, encoder_count, sensor_valid,
                               front_mm, left_mm, right_mm);
        if (want.done) stop_cnt++;
        expected_cmds.push_back(want);
      end
    end
    errors <= err_cnt;
    pending <= expected_cmds.size();
    checked <= result_cnt;
    stops <= stop_cnt;
  end

endmodule

[verif/corridor_centering_anchor_brake_test.sv]
`timescale 1ns / 1ps

module corridor_centering_anchor_brake_test;
  import cacb_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               begin_run = 1'b0;
  logic signed [31:0] encoder_count = '0;
  logic               sensor_valid = 1'b0;
  logic signed [13:0] front_mm = '0;
  logic signed [13:0] left_mm = '0;
  logic signed [13:0] right_mm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] left_target;
  logic signed [15:0] right_target;
  logic               blind_active;
  logic               done_res;

  int errors, pending, checked, stops;

  // stimulus control
  cacb_cfg_t cur;
  logic      idle_on = 1'b1;
  int        stall_run = 0;
  int        sent = 0;
  int        settings = 1;

  corridor_centering_anchor_brake dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .begin_run(begin_run), .encoder_count(encoder_count), .sensor_valid(sensor_valid),
    .front_mm(front_mm), .left_mm(left_mm), .right_mm(right_mm),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_target(left_target), .right_target(right_target),
    .blind_active(blind_active), .done_res(done_res)
  );

  wheel_target_checker targets_chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .begin_run(begin_run), .encoder_count(encoder_count), .sensor_valid(sensor_valid),
    .front_mm(front_mm), .left_mm(left_mm), .right_mm(right_mm),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_target(left_target), .right_target(right_target),
    .blind_active(blind_active), .done_res(done_res),
    .errors(errors), .pending(pending), .checked(checked), .stops(stops)
  );

  always #6 clk = ~clk;

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // side reading: below the wall threshold most of the time, some odd values
  function automatic logic [13:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return 14'h3FFF;
      1:       return $urandom;
      2, 3:    return $urandom_range(0, cur.center_half_mm / 2 + 2);
      4, 5, 6: return $urandom_range(0, cur.side_wall_mm + 10);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (!rst && idle_on && $urandom_range(0, 99) < 30) begin
      stall_run <= idle_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // back-to-back register write, valid left high for the next one
  task automatic write_reg(input cacb_reg_t idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // one tick word, then an optional gap
  task automatic send_tick(input logic go, input logic [31:0] enc, input logic sv,
                           input logic [13:0] f, input logic [13:0] l, input logic [13:0] r);
    int gap;
    in_valid <= 1'b1;
    begin_run <= go;
    encoder_count <= enc;
    sensor_valid <= sv;
    front_mm <= f;
    left_mm <= l;
    right_mm <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    cacb_cfg_t   s;
    logic [31:0] enc;
    logic        down;
    int unsigned stride_max;
    int          fr, len, quota, ph, k, n;

    cur = '{BASE_SPEED_RST, STOP_DIST_MM_RST, WALL_GAIN_RST, CENTER_HALF_MM_RST,
            SIDE_WALL_MM_RST, ANCHOR_MM_RST, TICKS_PER_CM_RST, CORRECTION_LIMIT_RST};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        // drain the pipe before touching the registers
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        case (ph)
          1: s = '{15'h7FFF, 10'h3FF, 8'hFF, 8'hFF, 13'h1FFF, 13'h1FFF, 8'hFF, 14'h3FFF};
          2: s = '{15'h0, 10'h0, 8'h0, 8'h0, 13'h0, 13'h1FFF, 8'h0, 14'h0};
          3: begin
            s = cur;
            s = '{BASE_SPEED_RST, STOP_DIST_MM_RST, WALL_GAIN_RST, CENTER_HALF_MM_RST,
                  SIDE_WALL_MM_RST, ANCHOR_MM_RST, 8'd1, CORRECTION_LIMIT_RST};
          end
          default: begin
            s.base_speed = $urandom_range(0, 16384);
            s.stop_dist_mm = $urandom_range(0, 200);
            s.wall_gain = $urandom_range(0, 255);
            s.center_half_mm = $urandom_range(0, 255);
            s.side_wall_mm = $urandom_range(0, 400);
            s.anchor_mm = $urandom_range(0, 600);
            s.ticks_per_cm = $urandom_range(1, 255);
            s.correction_limit = $urandom_range(0, 8192);
          end
        endcase
        write_reg(REG_BASE_SPEED, s.base_speed);
        write_reg(REG_STOP_DIST_MM, s.stop_dist_mm);
        write_reg(REG_WALL_GAIN, s.wall_gain);
        write_reg(REG_CENTER_HALF_MM, s.center_half_mm);
        write_reg(REG_SIDE_WALL_MM, s.side_wall_mm);
        write_reg(REG_ANCHOR_MM, s.anchor_mm);
        write_reg(REG_TICKS_PER_CM, s.ticks_per_cm);
        write_reg(REG_CORRECTION_LIMIT, s.correction_limit);
        cfg_valid <= 1'b0;
        cur = s;
        settings++;
      end

      if (ph == 0) begin
        // steering cases under reset settings
        send_tick(1, 32'h0, 1, 8190, -1, -1);
        send_tick(0, 32'h7FFFFFFF, 0, 14'h2000, 8191, 14'h2000);
        send_tick(0, 32'h80000000, 1, 8191, 0, 149);
        send_tick(0, 32'h1, 1, 8000, 10, 8191);
        send_tick(0, 32'h2, 1, 0, 30, 8191);
        send_tick(0, 32'h3, 1, -1, 8191, 20);
        send_tick(0, 32'h4, 1, 200, 149, 0);
        send_tick(0, 32'h5, 1, 14'h2000, 150, 150);
        send_tick(0, 32'h6, 0, 100, 0, 0);
        // anchor, blind braking across encoder wrap, then held done
        send_tick(0, 32'hFFFFFFF0, 1, 100, 100, 120);
        send_tick(0, 32'h50, 1, 50, 40, 8191);
        send_tick(0, 32'h7A, 1, 50, 0, 0);
        send_tick(0, 32'h100, 1, 30, 0, 0);
        // front already inside stop distance
        send_tick(1, 32'h100, 1, 30, 0, 0);
        // short target reached going backward
        send_tick(1, 32'h5, 1, 41, 0, 0);
        send_tick(0, 32'h4, 0, 0, 0, 0);
        send_tick(0, 32'h3, 0, 0, 0, 0);
        // half-range encoder distance
        send_tick(1, 32'h0, 1, 50, 0, 0);
        send_tick(0, 32'h80000000, 0, 0, 0, 0);
        send_tick(1, 32'h9, 1, 1, 8191, 8191);
        send_tick(1, 32'h9, 1, 40, 8191, 8191);
        send_tick(1, 32'h9, 0, 8191, 8191, 8191);
      end else if (ph == 3) begin
        // zero tick target ends on the anchor tick
        send_tick(1, 32'h0, 1, 45, 200, 200);
        send_tick(0, 32'h7, 1, 45, 200, 200);
        send_tick(1, 32'h0, 1, 60, 200, 200);
        send_tick(0, 32'h1, 1, 60, 200, 200);
        send_tick(0, 32'h2, 1, 60, 200, 200);
      end

      // random runs toward the anchor, with some noise words
      quota = sent + 95;
      while (sent < quota) begin
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            send_tick($urandom_range(0, 19) == 0, $urandom, $urandom_range(0, 1),
                      $urandom, $urandom, $urandom);
        end else begin
          case ($urandom_range(0, 3))
            0:       enc = 32'h7FFFFFC0;
            1:       enc = 32'hFFFFFFC0;
            default: enc = $urandom;
          endcase
          down = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 7))
            0, 1, 2: stride_max = 4;
            3, 4:    stride_max = 40;
            5, 6:    stride_max = 400;
            default: stride_max = 32'h3FFFFFFF;
          endcase
          fr = (cur.anchor_mm > 7990) ? 7960 : int'(cur.anchor_mm);
          fr = fr + int'($urandom_range(0, 60));
          len = $urandom_range(4, 24);
          for (k = 0; k < len; k++) begin
            fr = fr - int'($urandom_range(0, 12));
            if (fr < -1) fr = -1;
            if (down) enc = enc - $urandom_range(0, stride_max);
            else enc = enc + $urandom_range(0, stride_max);
            send_tick(k == 0 || $urandom_range(0, 39) == 0, enc, $urandom_range(0, 9) != 0,
                      fr[13:0], pick_side(), pick_side());
          end
        end
      end
    end

    // let the last words drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d tick results under %0d register settings, with and without idling.",
             checked, settings);
    $display("%0d ticks answered with the run ended; %0d mismatching words.", stops, errors);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[corridor_centering_anchor_brake.f]
design/cacb_pkg.sv
design/cacb_steer.sv
design/corridor_centering_anchor_brake.sv
verif/wheel_target_checker.sv
verif/corridor_centering_anchor_brake_test.sv
